>>> hdl/lbxp_pkg.sv
// ----------------------------------------------------------------------------
// lbxp_pkg
// Shared codes and widths for the bank-mixed LCG / xor-add random generator.
// ----------------------------------------------------------------------------
package lbxp_pkg;

  localparam int WORD_W = 64;
  localparam int SEL_W  = 3;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;
  localparam int N_ARR  = 6;

  // item kinds, carried in tuser
  localparam logic KIND_GEN  = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // load targets; also the index of each word store
  localparam logic [SEL_W-1:0] SEL_LCG_MULT = 3'd0;
  localparam logic [SEL_W-1:0] SEL_LCG_ADD  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_LCG_VAL  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_MIX_MASK = 3'd3;
  localparam logic [SEL_W-1:0] SEL_MIX_ADD  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MIX_VAL  = 3'd5;

  // register map (index taken from paddr[2])
  localparam logic REG_ENTRIES = 1'b0;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

endpackage

>>> hdl/lbxp_ram.sv
// ----------------------------------------------------------------------------
// lbxp_ram
// One-write one-read word store, registered read, with a bypass for a write
// that lands on the read address at the same edge.
// ----------------------------------------------------------------------------
module lbxp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] byp_data;
  logic             byp_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      byp_hit  <= we && (waddr == raddr);
      byp_data <= wdata;
    end
  end

  assign rdata = byp_hit ? byp_data : rd_q;

endmodule

>>> hdl/lcg_bank_xor_mixed_prng_unit.sv
// ----------------------------------------------------------------------------
// lcg_bank_xor_mixed_prng_unit
// Random generator: a bank of 64-bit LCGs whose output is xored with a bank
// of xor-add mixers, all words held in synchronous stores.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: kind; tdata: select, index, word
//  m_*       out  m_tvalid/m_tready  tdata: random value
//  apb       in   psel/penable       entries_in_use at byte address 0
//
//  One item per cycle while s_tready is high. A generated value goes through the
//  store read and partial products, then the sum into the output register.
//  An item waits while one ahead, in stage 1 or stalled in stage 2, still updates
//  an entry that the pointers select: every item after a generate item when the
//  entry count is zero or one, and an item after a load to such an entry.
//  After reset the stores are cleared entry by entry with s_tready low.
//  A stalled output fills the two internal stages before s_tready drops.
// ----------------------------------------------------------------------------
module lcg_bank_xor_mixed_prng_unit
  import lbxp_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // array_select[2:0], entry_index[6:3], load_value[70:7]
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // random_value[63:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW0 = $clog2(MAX_ENTRIES + 1);
  localparam int NW  = (NW0 > CFG_W) ? NW0 : CFG_W;
  localparam int IXW = (AW > IDX_W) ? AW : IDX_W;

  typedef struct packed {
    logic              gen;
    logic [N_ARR-1:0]  ld_we;
    logic [AW-1:0]     ld_addr;
    logic [AW-1:0]     p;
    logic [AW-1:0]     q;
    logic              wrap;
  } ctl_t;

  // configuration
  logic [CFG_W-1:0] entries_in_use;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_wr) begin
      entries_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENTRIES) ? 32'(entries_in_use) : '0;

  // clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // input fields
  logic              in_kind;
  logic [SEL_W-1:0]  in_sel;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_word;
  logic [IXW-1:0]    in_idx_ext;
  logic              idx_ok;

  assign in_kind    = s_tuser[0];
  assign in_sel     = s_tdata[2:0];
  assign in_idx     = s_tdata[6:3];
  assign in_word    = s_tdata[70:7];
  assign in_idx_ext = IXW'(in_idx);
  assign idx_ok     = (32'(in_idx) < MAX_ENTRIES);

  // pointers and effective count
  logic [AW-1:0] lcg_ptr, mix_ptr;
  logic [NW-1:0] eff_n, cnt_ext, p_inc, q_inc;
  logic          p_wrap, q_wrap;

  assign cnt_ext = NW'(entries_in_use);
  always_comb begin
    if (entries_in_use == '0) begin
      eff_n = NW'(1);
    end else if (cnt_ext > NW'(MAX_ENTRIES)) begin
      eff_n = NW'(MAX_ENTRIES);
    end else begin
      eff_n = cnt_ext;
    end
  end

  assign p_inc  = NW'(lcg_ptr) + NW'(1);
  assign q_inc  = NW'(mix_ptr) + NW'(1);
  assign p_wrap = (p_inc >= eff_n);
  assign q_wrap = (q_inc >= eff_n);

  // pipeline control
  logic  s1_v, s2_v;
  ctl_t  ctl1, ctl2, ctl_in;
  logic  s2_go, s2_free, s1_free, hazard, accept;

  function automatic logic conflicts(ctl_t c, logic [AW-1:0] p, logic [AW-1:0] q);
    logic lcg_hit, mix_hit;
    lcg_hit = (c.gen && (c.p == p)) ||
              ((|c.ld_we[SEL_LCG_VAL:SEL_LCG_MULT]) && (c.ld_addr == p));
    mix_hit = (c.gen && c.wrap && (c.q == q)) ||
              ((|c.ld_we[SEL_MIX_VAL:SEL_MIX_MASK]) && (c.ld_addr == q));
    return lcg_hit || mix_hit;
  endfunction

  assign s2_go   = s2_v && (!ctl2.gen || !m_tvalid || m_tready);
  assign s2_free = !s2_v || s2_go;
  assign s1_free = !s1_v || s2_free;
  assign hazard  = (s1_v && conflicts(ctl1, lcg_ptr, mix_ptr)) ||
                   (s2_v && !s2_go && conflicts(ctl2, lcg_ptr, mix_ptr));
  assign s_tready = !clearing && s1_free && !hazard;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ctl_in.gen     = (in_kind == KIND_GEN);
    ctl_in.ld_addr = in_idx_ext[AW-1:0];
    ctl_in.p       = lcg_ptr;
    ctl_in.q       = mix_ptr;
    ctl_in.wrap    = p_wrap;
    for (int k = 0; k < N_ARR; k++) begin
      ctl_in.ld_we[k] = (in_kind == KIND_LOAD) && idx_ok && (in_sel == SEL_W'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_ptr <= '0;
      mix_ptr <= '0;
    end else if (accept && (in_kind == KIND_GEN)) begin
      // advance; the mixer steps when the LCG pointer wraps
      lcg_ptr <= p_wrap ? '0 : p_inc[AW-1:0];
      if (p_wrap) begin
        mix_ptr <= q_wrap ? '0 : q_inc[AW-1:0];
      end
    end
  end

  // word stores
  logic [N_ARR-1:0]  mem_we;
  logic [AW-1:0]     mem_waddr [N_ARR];
  logic [WORD_W-1:0] mem_wdata [N_ARR];
  logic [WORD_W-1:0] mem_rdata [N_ARR];
  logic [WORD_W-1:0] fresh, mix_new2, ld_val2;

  always_comb begin
    for (int k = 0; k < N_ARR; k++) begin
      if (clearing) begin
        mem_we[k]    = 1'b1;
        mem_waddr[k] = clr_addr;
        mem_wdata[k] = '0;
      end else begin
        mem_we[k]    = s2_go && ctl2.ld_we[k];
        mem_waddr[k] = ctl2.ld_addr;
        mem_wdata[k] = ld_val2;
      end
    end
    if (!clearing && s2_go && ctl2.gen) begin
      mem_we[SEL_LCG_VAL]    = 1'b1;
      mem_waddr[SEL_LCG_VAL] = ctl2.p;
      mem_wdata[SEL_LCG_VAL] = fresh;
      mem_we[SEL_MIX_VAL]    = ctl2.wrap;
      mem_waddr[SEL_MIX_VAL] = ctl2.q;
      mem_wdata[SEL_MIX_VAL] = mix_new2;
    end
  end

  for (genvar g = 0; g < N_ARR; g++) begin : g_store
    lbxp_ram #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (WORD_W)
    ) u_store (
      .clk   (clk),
      .we    (mem_we[g]),
      .waddr (mem_waddr[g]),
      .wdata (mem_wdata[g]),
      .re    (accept),
      .raddr ((g <= int'(SEL_LCG_VAL)) ? lcg_ptr : mix_ptr),
      .rdata (mem_rdata[g])
    );
  end

  // stage 1: partial products and mixer step
  logic [WORD_W-1:0] ld_val1;
  logic [WORD_W-1:0] a1, x1;
  logic [63:0]       pp_ll;
  logic [63:0]       pp_lh, pp_hl;
  logic [WORD_W-1:0] mix_new1;

  assign a1       = mem_rdata[SEL_LCG_MULT];
  assign x1       = mem_rdata[SEL_LCG_VAL];
  assign pp_ll    = a1[31:0] * x1[31:0];
  assign pp_lh    = a1[31:0] * x1[63:32];
  assign pp_hl    = a1[63:32] * x1[31:0];
  assign mix_new1 = (mem_rdata[SEL_MIX_MASK] ^ mem_rdata[SEL_MIX_VAL])
                    + mem_rdata[SEL_MIX_ADD];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1    <= ctl_in;
      ld_val1 <= in_word;
    end
  end

  // stage 2: sum, xor and write back
  logic [63:0]       ll2;
  logic [31:0]       lh2, hl2;
  logic [WORD_W-1:0] b2, mv2;
  logic [31:0]       cross2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v) begin
      ctl2     <= ctl1;
      ll2      <= pp_ll;
      lh2      <= pp_lh[31:0];
      hl2      <= pp_hl[31:0];
      b2       <= mem_rdata[SEL_LCG_ADD];
      mv2      <= mem_rdata[SEL_MIX_VAL];
      mix_new2 <= mix_new1;
      ld_val2  <= ld_val1;
    end
  end

  assign cross2 = lh2 + hl2;
  assign fresh  = (ll2 + {cross2, 32'b0} + b2) ^ mv2;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_go && ctl2.gen) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && ctl2.gen) begin
      m_tdata <= fresh;
    end
  end

endmodule
